// ===== rtl/sscf_pkg.sv =====
// shared types, codes and channel range table for the sensor sample controller
// no dependencies
package sscf_pkg;

  localparam int DEF_BUFFER_DEPTH = 16;
  localparam int DEF_CHANNELS     = 4;

  typedef enum logic [3:0] {
    KIND_ENABLE  = 4'd0,
    KIND_DISABLE = 4'd1,
    KIND_TRIGGER = 4'd2,
    KIND_UPDATE  = 4'd3,
    KIND_LOAD    = 4'd4,
    KIND_PUSH    = 4'd5,
    KIND_POP     = 4'd6,
    KIND_CLEAR   = 4'd7,
    KIND_READ    = 4'd8
  } kind_e;

  typedef enum logic [1:0] {
    MODE_DISABLED = 2'd0,
    MODE_IDLE     = 2'd1,
    MODE_SAMPLING = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REFUSED = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT,
    S_UPD,
    S_OUT
  } fsm_e;

  typedef struct packed {
    logic push;
    logic pop;
    logic rd;
    logic clear;
  } ring_ctrl_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [3:0] count;
  } ring_stat_t;

  localparam logic signed [31:0] RANGE_LO [4] = '{-32'sd10000, 32'sd0, -32'sd40, 32'sd0};
  localparam logic signed [31:0] RANGE_HI [4] = '{32'sd10000, 32'sd10000, 32'sd125, 32'sd5000};

  function automatic logic signed [31:0] clamp_chan(input logic [1:0] ch,
                                                    input logic signed [31:0] v);
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic signed [31:0] r;
    lo = RANGE_LO[ch];
    hi = RANGE_HI[ch];
    r  = v;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

endpackage

// ===== rtl/sensor_sample_controller_fifo_unit.sv =====
// Four-channel sensor sampler with a sample ring buffer. One item is taken at a time and
// yields one result item. Enable, disable, trigger, load, push, clear and unused kinds pass
// through the accepting state, one execute state and the state that loads the result
// register. Pop and read channel add a wait state for the registered read of the ring
// memory or the channel value memory, except for a pop of an empty ring or a read of an
// out-of-range channel. Update visits one channel per cycle through the single read port
// of the channel value memory, the read of the next channel overlapping the clamp and
// write-back of the current one, and a last step clamps and writes back the last channel.
// A finished result sits in an output register, so the next item is accepted while it
// waits to be taken. The ring holds at most BUFFER_DEPTH-1 entries. The continuous-sampling
// bit is written through cfg_we_i / cfg_wdata_i.
// depends on sscf_pkg and sscf_ring
module sensor_sample_controller_fifo_unit #(
  parameter int BUFFER_DEPTH = sscf_pkg::DEF_BUFFER_DEPTH,
  parameter int CHANNELS     = sscf_pkg::DEF_CHANNELS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  kind_i,
  input  logic [1:0]  sensor_id_i,
  input  logic signed [31:0] sample_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic signed [31:0] read_value_o,
  output logic [1:0]  channel_mode_o,
  output logic [3:0]  buffer_count_o,
  output logic        enabled_flag_o,
  output logic        ready_flag_o,
  output logic        overflow_flag_o,
  output logic        trigger_flag_o
);

  localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int UCW = $clog2(CHANNELS + 1);

  sscf_pkg::fsm_e state_q, state_d;

  // item registers
  logic [3:0]         kind_q;
  logic [1:0]         id_q;
  logic signed [31:0] val_q;

  logic cont_q;
  logic en_q, en_d, rdy_q, rdy_d, trig_q, trig_d, ovf_q, ovf_d;
  sscf_pkg::mode_e chst_q [CHANNELS];
  sscf_pkg::mode_e chst_d [CHANNELS];
  sscf_pkg::status_e status_q, status_d;
  logic signed [31:0] rval_q, rval_d;
  logic [UCW-1:0] cnt_q, cnt_d;

  // channel value memory
  logic signed [31:0] chan_mem [CHANNELS];
  logic               chan_vld_q [CHANNELS];
  logic signed [31:0] chan_rdata_q;
  logic               chan_rvld_q;
  logic signed [31:0] chan_rd;
  logic               chan_we, chan_re;
  logic [CIW-1:0]     chan_waddr, chan_raddr;
  logic signed [31:0] chan_wdata;

  sscf_pkg::ring_ctrl_t ring_ctrl;
  sscf_pkg::ring_stat_t ring_stat;
  logic [31:0]          ring_rdata;
  logic signed [31:0]   push_data;

  logic           id_ok;
  logic [CIW-1:0] id_idx;
  logic [UCW-1:0] prev_cnt;
  logic [CIW-1:0] proc_idx;
  logic           out_load;
  logic           accept;

  assign id_ok    = ({1'b0, id_q} < 3'(CHANNELS));
  assign id_idx   = id_q[CIW-1:0];
  assign prev_cnt = cnt_q - UCW'(1);
  assign proc_idx = prev_cnt[CIW-1:0];
  assign chan_rd  = chan_rvld_q ? chan_rdata_q : '0;
  assign accept   = in_valid_i && in_ready_o;
  assign out_load = (state_q == sscf_pkg::S_OUT) && (!out_valid_o || out_ready_i);

  sscf_ring #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ring_ctrl),
    .push_data_i(push_data),
    .stat_o     (ring_stat),
    .rdata_o    (ring_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sscf_pkg::S_IDLE: begin
        if (in_valid_i) state_d = sscf_pkg::S_EXEC;
      end
      sscf_pkg::S_EXEC: begin
        unique case (kind_q)
          sscf_pkg::KIND_UPDATE: state_d = sscf_pkg::S_UPD;
          sscf_pkg::KIND_POP:
            state_d = ring_stat.empty ? sscf_pkg::S_OUT : sscf_pkg::S_WAIT;
          sscf_pkg::KIND_READ:
            state_d = id_ok ? sscf_pkg::S_WAIT : sscf_pkg::S_OUT;
          default: state_d = sscf_pkg::S_OUT;
        endcase
      end
      sscf_pkg::S_WAIT: state_d = sscf_pkg::S_OUT;
      sscf_pkg::S_UPD: begin
        if (cnt_q == UCW'(CHANNELS)) state_d = sscf_pkg::S_OUT;
      end
      sscf_pkg::S_OUT: begin
        if (out_load) state_d = sscf_pkg::S_IDLE;
      end
      default: state_d = sscf_pkg::S_IDLE;
    endcase
  end

  // datapath and memory commands
  always_comb begin
    logic signed [31:0] cv;
    chst_d     = chst_q;
    en_d       = en_q;
    rdy_d      = rdy_q;
    trig_d     = trig_q;
    ovf_d      = ovf_q;
    status_d   = status_q;
    rval_d     = rval_q;
    cnt_d      = cnt_q;
    chan_we    = 1'b0;
    chan_re    = 1'b0;
    chan_waddr = id_idx;
    chan_raddr = id_idx;
    chan_wdata = val_q;
    ring_ctrl  = '0;
    push_data  = val_q;
    cv         = chan_rd;

    unique case (state_q)
      sscf_pkg::S_IDLE: begin
        if (in_valid_i) begin
          status_d = sscf_pkg::ST_OK;
          rval_d   = '0;
          cnt_d    = '0;
        end
      end
      sscf_pkg::S_EXEC: begin
        unique case (kind_q)
          sscf_pkg::KIND_ENABLE: begin
            for (int i = 0; i < CHANNELS; i++) chst_d[i] = sscf_pkg::MODE_IDLE;
            en_d  = 1'b1;
            rdy_d = 1'b1;
          end
          sscf_pkg::KIND_DISABLE: begin
            for (int i = 0; i < CHANNELS; i++) chst_d[i] = sscf_pkg::MODE_DISABLED;
            en_d  = 1'b0;
            rdy_d = 1'b0;
          end
          sscf_pkg::KIND_TRIGGER: begin
            if (en_q) begin
              trig_d = 1'b1;
              for (int i = 0; i < CHANNELS; i++) begin
                if (chst_q[i] == sscf_pkg::MODE_IDLE) chst_d[i] = sscf_pkg::MODE_SAMPLING;
              end
            end else begin
              status_d = sscf_pkg::ST_REFUSED;
            end
          end
          sscf_pkg::KIND_LOAD: begin
            chan_we = id_ok;
          end
          sscf_pkg::KIND_PUSH: begin
            ring_ctrl.push = 1'b1;
            if (ring_stat.full) begin
              ovf_d    = 1'b1;
              status_d = sscf_pkg::ST_FULL;
            end
          end
          sscf_pkg::KIND_POP: begin
            if (ring_stat.empty) begin
              status_d = sscf_pkg::ST_EMPTY;
            end else begin
              ring_ctrl.rd = 1'b1;
            end
          end
          sscf_pkg::KIND_CLEAR: begin
            ring_ctrl.clear = 1'b1;
            ovf_d           = 1'b0;
          end
          sscf_pkg::KIND_READ: begin
            chan_re = id_ok;
          end
          default: ;
        endcase
      end
      sscf_pkg::S_WAIT: begin
        if (kind_q == sscf_pkg::KIND_POP) begin
          rval_d        = ring_rdata;
          ring_ctrl.pop = 1'b1;
        end else begin
          rval_d = chan_rd;
        end
      end
      sscf_pkg::S_UPD: begin
        // read channel cnt while clamping channel cnt-1
        if (cnt_q < UCW'(CHANNELS)) begin
          chan_re    = 1'b1;
          chan_raddr = cnt_q[CIW-1:0];
          cnt_d      = cnt_q + UCW'(1);
        end
        if (cnt_q != '0 && chst_q[proc_idx] == sscf_pkg::MODE_SAMPLING) begin
          cv                 = sscf_pkg::clamp_chan(2'(proc_idx), chan_rd);
          chst_d[proc_idx]   = sscf_pkg::MODE_IDLE;
          chan_we            = 1'b1;
          chan_waddr         = proc_idx;
          chan_wdata         = cv;
          push_data          = cv;
          if (cont_q) begin
            ring_ctrl.push = 1'b1;
            if (ring_stat.full) ovf_d = 1'b1;
          end
        end
        if (cnt_q == UCW'(CHANNELS)) begin
          trig_d = 1'b0;
          if (cont_q && rdy_q && en_q) begin
            trig_d = 1'b1;
            for (int i = 0; i < CHANNELS; i++) begin
              if (chst_d[i] == sscf_pkg::MODE_IDLE) chst_d[i] = sscf_pkg::MODE_SAMPLING;
            end
          end
        end
      end
      sscf_pkg::S_OUT: ;
      default: ;
    endcase
  end

  assign in_ready_o = (state_q == sscf_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sscf_pkg::S_IDLE;
      cont_q   <= 1'b0;
      en_q     <= 1'b0;
      rdy_q    <= 1'b0;
      trig_q   <= 1'b0;
      ovf_q    <= 1'b0;
      status_q <= sscf_pkg::ST_OK;
      cnt_q    <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        chst_q[i]     <= sscf_pkg::MODE_DISABLED;
        chan_vld_q[i] <= 1'b0;
      end
      out_valid_o <= 1'b0;
    end else begin
      state_q  <= state_d;
      en_q     <= en_d;
      rdy_q    <= rdy_d;
      trig_q   <= trig_d;
      ovf_q    <= ovf_d;
      status_q <= status_d;
      cnt_q    <= cnt_d;
      chst_q   <= chst_d;
      if (cfg_we_i) cont_q <= cfg_wdata_i;
      if (chan_we) chan_vld_q[chan_waddr] <= 1'b1;
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rval_q <= rval_d;
    if (accept) begin
      kind_q <= kind_i;
      id_q   <= sensor_id_i;
      val_q  <= sample_value_i;
    end
    if (out_load) begin
      status_o        <= status_q;
      read_value_o    <= rval_q;
      channel_mode_o  <= id_ok ? chst_q[id_idx] : sscf_pkg::MODE_DISABLED;
      buffer_count_o  <= ring_stat.count;
      enabled_flag_o  <= en_q;
      ready_flag_o    <= rdy_q;
      overflow_flag_o <= ovf_q;
      trigger_flag_o  <= trig_q;
    end
  end

  // channel value memory, entries read as zero until first written
  always_ff @(posedge clk_i) begin
    if (chan_we) chan_mem[chan_waddr] <= chan_wdata;
    if (chan_re) begin
      chan_rdata_q <= chan_mem[chan_raddr];
      chan_rvld_q  <= chan_vld_q[chan_raddr];
    end
  end

endmodule

// ===== rtl/sscf_ring.sv =====
// sample ring buffer: one synchronous memory plus write and read pointers
// depends on sscf_pkg
module sscf_ring #(
  parameter int BUFFER_DEPTH = sscf_pkg::DEF_BUFFER_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sscf_pkg::ring_ctrl_t ctrl_i,
  input  logic [31:0]          push_data_i,
  output sscf_pkg::ring_stat_t stat_o,
  output logic [31:0]          rdata_o
);

  localparam int PW = $clog2(BUFFER_DEPTH);
  localparam int CW = PW + 1;

  logic [31:0]   mem [BUFFER_DEPTH];
  logic [31:0]   rdata_q;
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW-1:0] wr_nxt, rd_nxt;
  logic [CW-1:0] diff;
  logic [31:0]   diff_wide;
  logic          full;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(BUFFER_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign wr_nxt = ptr_inc(wr_ptr_q);
  assign rd_nxt = ptr_inc(rd_ptr_q);
  // one slot stays free
  assign full   = (wr_nxt == rd_ptr_q);

  always_comb begin
    if (wr_ptr_q >= rd_ptr_q) begin
      diff = {1'b0, wr_ptr_q} - {1'b0, rd_ptr_q};
    end else begin
      diff = {1'b0, wr_ptr_q} + CW'(BUFFER_DEPTH) - {1'b0, rd_ptr_q};
    end
  end

  assign diff_wide    = 32'(diff);
  assign stat_o.full  = full;
  assign stat_o.empty = (wr_ptr_q == rd_ptr_q);
  assign stat_o.count = diff_wide[3:0];
  assign rdata_o      = rdata_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (ctrl_i.clear) begin
      wr_ptr_d = '0;
      rd_ptr_d = '0;
    end else begin
      if (ctrl_i.push && !full) wr_ptr_d = wr_nxt;
      if (ctrl_i.pop) rd_ptr_d = rd_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && !full && !ctrl_i.clear) begin
      mem[wr_ptr_q] <= push_data_i;
    end
    if (ctrl_i.rd) begin
      rdata_q <= mem[rd_ptr_q];
    end
  end

endmodule

// ===== rtl/sscf_checker.sv =====
// port-level checks on the sensor sample controller results, bound to the top level
// depends on sscf_pkg and sensor_sample_controller_fifo_unit
module sscf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [31:0] read_value_o,
  input logic [3:0]  buffer_count_o,
  input logic        enabled_flag_o,
  input logic        ready_flag_o,
  input logic        overflow_flag_o
);

  // a waiting item holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_value_o) && $stable(status_o))
    else $error("result item changed while stalled");

  a_refused_disabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == sscf_pkg::ST_REFUSED |-> !enabled_flag_o)
    else $error("trigger refused while enabled");

  a_full_sets_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == sscf_pkg::ST_FULL |-> overflow_flag_o)
    else $error("full push without overflow flag");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == sscf_pkg::ST_EMPTY |-> buffer_count_o == 4'd0 &&
    read_value_o == 32'd0)
    else $error("empty pop with data or nonzero count");

  // enable and ready always move together
  a_ready_tracks_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ready_flag_o == enabled_flag_o)
    else $error("ready flag differs from enable flag");

endmodule

bind sensor_sample_controller_fifo_unit sscf_checker u_sscf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .read_value_o   (read_value_o),
  .buffer_count_o (buffer_count_o),
  .enabled_flag_o (enabled_flag_o),
  .ready_flag_o   (ready_flag_o),
  .overflow_flag_o(overflow_flag_o)
);

// ===== tb/tb_sensor_sample_controller_fifo_unit.sv =====
// testbench for sensor_sample_controller_fifo_unit: directed table, then random phases
// checked against an in-bench predictor of the channels, control bits and sample ring
// depends on sscf_pkg and the unit's rtl
`timescale 1ns / 1ps

module tb_sensor_sample_controller_fifo_unit;

  localparam int HOLD_OFF       = 10;
  localparam int DRAIN_TAIL     = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_WAIT       = 14;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 150;
  localparam logic [3:0] KIND_SPARE_FIRST = 4'd9;
  localparam logic [3:0] KIND_SPARE_LAST  = 4'd15;
  localparam int CH_LO [4] = '{-10000, 0, -40, 0};
  localparam int CH_HI [4] = '{10000, 10000, 125, 5000};

  typedef struct packed {
    sscf_pkg::status_e  status;
    logic signed [31:0] read_value;
    sscf_pkg::mode_e    mode;
    logic [3:0]         count;
    logic               enabled;
    logic               ready;
    logic               overflow;
    logic               trigger;
  } sample_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e          rk;
    logic [3:0]         kind;
    logic [1:0]         id;
    logic signed [31:0] val;
    bit                 fixed;
    sample_result_t     want;
  } step_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [3:0]         kind_i;
  logic [1:0]         sensor_id_i;
  logic signed [31:0] sample_value_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [1:0]         status_o;
  logic signed [31:0] read_value_o;
  logic [1:0]         channel_mode_o;
  logic [3:0]         buffer_count_o;
  logic               enabled_flag_o;
  logic               ready_flag_o;
  logic               overflow_flag_o;
  logic               trigger_flag_o;

  sensor_sample_controller_fifo_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .sensor_id_i     (sensor_id_i),
    .sample_value_i  (sample_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .read_value_o    (read_value_o),
    .channel_mode_o  (channel_mode_o),
    .buffer_count_o  (buffer_count_o),
    .enabled_flag_o  (enabled_flag_o),
    .ready_flag_o    (ready_flag_o),
    .overflow_flag_o (overflow_flag_o),
    .trigger_flag_o  (trigger_flag_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // predicted block state
  int              chan_val [4];
  sscf_pkg::mode_e chan_mode [4];
  int              ring_mem [16];
  logic [3:0]      wr_ptr;
  logic [3:0]      rd_ptr;
  logic            en_q;
  logic            rdy_q;
  logic            trig_q;
  logic            ovf_q;
  logic            cont_q;

  sample_result_t expected_samples [$];
  step_row_t      dir_rows [$];
  bit             no_idle;
  int             mismatch_count;
  int             checked_count;
  int             sent_items;
  int             useful_items;
  int             quiet_cycles;
  int             refused_cnt;
  int             dropped_cnt;
  int             empty_cnt;
  int             update_cnt;

  function automatic bit ring_put(int v);
    logic [3:0] nxt;
    nxt = wr_ptr + 4'd1;
    if (nxt == rd_ptr) begin
      ovf_q = 1'b1;
      dropped_cnt++;
      return 1'b0;
    end
    ring_mem[wr_ptr] = v;
    wr_ptr = nxt;
    return 1'b1;
  endfunction

  function automatic bit arm_channels();
    if (!en_q) return 1'b0;
    trig_q = 1'b1;
    for (int i = 0; i < 4; i++)
      if (chan_mode[i] == sscf_pkg::MODE_IDLE) chan_mode[i] = sscf_pkg::MODE_SAMPLING;
    return 1'b1;
  endfunction

  function automatic sample_result_t predict_sample(logic [3:0] kind, logic [1:0] id,
                                                    logic signed [31:0] val);
    sample_result_t r;
    int v;
    r = '0;
    case (kind)
      sscf_pkg::KIND_ENABLE: begin
        for (int i = 0; i < 4; i++) chan_mode[i] = sscf_pkg::MODE_IDLE;
        en_q = 1'b1;
        rdy_q = 1'b1;
      end
      sscf_pkg::KIND_DISABLE: begin
        for (int i = 0; i < 4; i++) chan_mode[i] = sscf_pkg::MODE_DISABLED;
        en_q = 1'b0;
        rdy_q = 1'b0;
      end
      sscf_pkg::KIND_TRIGGER: begin
        if (!arm_channels()) begin
          r.status = sscf_pkg::ST_REFUSED;
          refused_cnt++;
        end
      end
      sscf_pkg::KIND_UPDATE: begin
        update_cnt++;
        for (int i = 0; i < 4; i++) begin
          if (chan_mode[i] == sscf_pkg::MODE_SAMPLING) begin
            v = chan_val[i];
            chan_mode[i] = sscf_pkg::MODE_IDLE;
            if (v < CH_LO[i]) v = CH_LO[i];
            if (v > CH_HI[i]) v = CH_HI[i];
            chan_val[i] = v;
            if (cont_q) void'(ring_put(v));
          end
        end
        trig_q = 1'b0;
        if (cont_q && rdy_q) void'(arm_channels());
      end
      sscf_pkg::KIND_LOAD: chan_val[id] = val;
      sscf_pkg::KIND_PUSH: begin
        if (!ring_put(val)) r.status = sscf_pkg::ST_FULL;
      end
      sscf_pkg::KIND_POP: begin
        if (wr_ptr == rd_ptr) begin
          r.status = sscf_pkg::ST_EMPTY;
          empty_cnt++;
        end else begin
          r.read_value = ring_mem[rd_ptr];
          rd_ptr = rd_ptr + 4'd1;
        end
      end
      sscf_pkg::KIND_CLEAR: begin
        wr_ptr = '0;
        rd_ptr = '0;
        ovf_q = 1'b0;
      end
      sscf_pkg::KIND_READ: r.read_value = chan_val[id];
      default: ;
    endcase
    r.mode     = chan_mode[id];
    r.count    = wr_ptr - rd_ptr;
    r.enabled  = en_q;
    r.ready    = rdy_q;
    r.overflow = ovf_q;
    r.trigger  = trig_q;
    return r;
  endfunction

  function automatic sample_result_t fixed_result(sscf_pkg::status_e s, sscf_pkg::mode_e m,
                                                  logic on);
    sample_result_t r;
    r = '0;
    r.status  = s;
    r.mode    = m;
    r.enabled = on;
    r.ready   = on;
    return r;
  endfunction

  function automatic logic signed [31:0] pick_sample();
    int ch;
    ch = $urandom_range(0, 3);
    case ($urandom_range(0, 5))
      0: return CH_LO[ch] - int'($urandom_range(0, 2));
      1: return CH_HI[ch] + int'($urandom_range(0, 2));
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      3: return int'($urandom_range(0, 20000)) - 10000;
      4: return int'($urandom_range(0, 300)) - 100;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(logic [3:0] kind, logic [1:0] id, logic signed [31:0] val,
                           bit fixed, sample_result_t want);
    int gap;
    sample_result_t pred;
    gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    sensor_id_i    <= id;
    sample_value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    pred = predict_sample(kind, id, val);
    expected_samples.push_back(fixed ? want : pred);
    sent_items++;
    if (kind <= sscf_pkg::KIND_READ) useful_items++;
  endtask

  task automatic issue(logic [3:0] kind, logic [1:0] id, logic signed [31:0] val);
    send_item(kind, id, val, 1'b0, '0);
  endtask

  // sender holds off until every outstanding result is back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_continuous(logic m);
    drain();
    repeat (HOLD_OFF) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cont_q = m;
  endtask

  // well-formed sampling sequence with random content
  task automatic sample_round();
    int loads;
    if (!en_q && $urandom_range(0, 3) != 0)
      issue(sscf_pkg::KIND_ENABLE, 2'($urandom_range(0, 3)), $urandom);
    loads = $urandom_range(1, 4);
    for (int i = 0; i < loads; i++)
      issue(sscf_pkg::KIND_LOAD, 2'($urandom_range(0, 3)), pick_sample());
    if ($urandom_range(0, 4) != 0)
      issue(sscf_pkg::KIND_TRIGGER, 2'($urandom_range(0, 3)), $urandom);
    issue(sscf_pkg::KIND_UPDATE, 2'($urandom_range(0, 3)), $urandom);
    repeat ($urandom_range(1, 2))
      issue(sscf_pkg::KIND_READ, 2'($urandom_range(0, 3)), $urandom);
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 4))
        issue(sscf_pkg::KIND_POP, 2'($urandom_range(0, 3)), $urandom);
  endtask

  task automatic random_item(bit push_heavy);
    int pick;
    logic [3:0] kind;
    pick = $urandom_range(0, 99);
    if (push_heavy && pick < 30) kind = sscf_pkg::KIND_PUSH;
    else if (pick < 6)  kind = sscf_pkg::KIND_ENABLE;
    else if (pick < 9)  kind = sscf_pkg::KIND_DISABLE;
    else if (pick < 21) kind = sscf_pkg::KIND_TRIGGER;
    else if (pick < 35) kind = sscf_pkg::KIND_UPDATE;
    else if (pick < 52) kind = sscf_pkg::KIND_LOAD;
    else if (pick < 66) kind = sscf_pkg::KIND_PUSH;
    else if (pick < 80) kind = sscf_pkg::KIND_POP;
    else if (pick < 83) kind = sscf_pkg::KIND_CLEAR;
    else if (pick < 96) kind = sscf_pkg::KIND_READ;
    else kind = 4'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
    issue(kind, 2'($urandom_range(0, 3)),
          (kind == sscf_pkg::KIND_LOAD || kind == sscf_pkg::KIND_PUSH) ?
          pick_sample() : $urandom);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // result checking and watchdog
  always @(posedge clk_i) begin
    sample_result_t want;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid_o && out_ready_i) begin
        if (expected_samples.size() == 0) begin
          $error("result item arrived with nothing outstanding");
          mismatch_count++;
        end else begin
          want = expected_samples.pop_front();
          check_field("status", want.status, status_o);
          check_field("read_value", want.read_value, read_value_o);
          check_field("channel_mode", want.mode, channel_mode_o);
          check_field("buffer_count", want.count, buffer_count_o);
          check_field("enabled_flag", want.enabled, enabled_flag_o);
          check_field("ready_flag", want.ready, ready_flag_o);
          check_field("overflow_flag", want.overflow, overflow_flag_o);
          check_field("trigger_flag", want.trigger, trigger_flag_o);
          checked_count++;
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 quiet_cycles, expected_samples.size());
        $display("sensor_sample_controller_fifo_unit verification failed");
        $finish;
      end
    end
  end

  // result side
  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    int directed_items;
    int start;
    bit heavy;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = 1'b0;
    in_valid_i     = 1'b0;
    kind_i         = sscf_pkg::KIND_ENABLE;
    sensor_id_i    = '0;
    sample_value_i = '0;
    no_idle        = 1'b0;
    mismatch_count = 0;
    checked_count  = 0;
    sent_items     = 0;
    useful_items   = 0;
    quiet_cycles   = 0;
    refused_cnt    = 0;
    dropped_cnt    = 0;
    empty_cnt      = 0;
    update_cnt     = 0;
    for (int i = 0; i < 4; i++) begin
      chan_val[i]  = 0;
      chan_mode[i] = sscf_pkg::MODE_DISABLED;
    end
    for (int i = 0; i < 16; i++) ring_mem[i] = 0;
    wr_ptr = '0;
    rd_ptr = '0;
    en_q   = 1'b0;
    rdy_q  = 1'b0;
    trig_q = 1'b0;
    ovf_q  = 1'b0;
    cont_q = 1'b0;

    dir_rows = '{
      '{ROW_CFG,  sscf_pkg::KIND_ENABLE,  2'd0, 32'sd0,        1'b0, '0},
      '{ROW_ITEM, sscf_pkg::KIND_TRIGGER, 2'd0, 32'sd0,        1'b1,
        fixed_result(sscf_pkg::ST_REFUSED, sscf_pkg::MODE_DISABLED, 1'b0)},
      '{ROW_ITEM, sscf_pkg::KIND_POP,     2'd1, 32'sd0,        1'b1,
        fixed_result(sscf_pkg::ST_EMPTY, sscf_pkg::MODE_DISABLED, 1'b0)},
      '{ROW_ITEM, sscf_pkg::KIND_READ,    2'd3, 32'sd0,        1'b1,
        fixed_result(sscf_pkg::ST_OK, sscf_pkg::MODE_DISABLED, 1'b0)},
      '{ROW_ITEM, sscf_pkg::KIND_LOAD,    2'd0, 32'sh7fffffff, 1'b1,
        fixed_result(sscf_pkg::ST_OK, sscf_pkg::MODE_DISABLED, 1'b0)},
      '{ROW_ITEM, sscf_pkg::KIND_LOAD,    2'd1, 32'sh80000000, 1'b1,
        fixed_result(sscf_pkg::ST_OK, sscf_pkg::MODE_DISABLED, 1'b0)},
      '{ROW_ITEM, sscf_pkg::KIND_LOAD,    2'd2, -32'sd41,      1'b0, '0},
      '{ROW_ITEM, sscf_pkg::KIND_LOAD,    2'd3, 32'sd5001,     1'b0, '0},
      '{ROW_ITEM, sscf_pkg::KIND_ENABLE,  2'd1, 32'sd0,        1'b1,
        fixed_result(sscf_pkg::ST_OK, sscf_pkg::MODE_IDLE, 1'b1)},
      '{ROW_ITEM, sscf_pkg::KIND_TRIGGER, 2'd2, 32'sd0,        1'b0, '0},
      '{ROW_ITEM, sscf_pkg::KIND_UPDATE,  2'd3, 32'sd0,        1'b0, '0},
      '{ROW_ITEM, sscf_pkg::KIND_READ,    2'd0, 32'sd0,        1'b0, '0},
      '{ROW_ITEM, sscf_pkg::KIND_READ,    2'd2, 32'sd0,        1'b0, '0},
      '{ROW_ITEM, sscf_pkg::KIND_PUSH,    2'd0, 32'sh7fffffff, 1'b0, '0},
      '{ROW_ITEM, sscf_pkg::KIND_PUSH,    2'd1, 32'sh80000000, 1'b0, '0},
      '{ROW_ITEM, sscf_pkg::KIND_POP,     2'd0, 32'sd0,        1'b0, '0},
      '{ROW_ITEM, sscf_pkg::KIND_POP,     2'd0, 32'sd0,        1'b0, '0},
      '{ROW_ITEM, KIND_SPARE_LAST,        2'd2, 32'shffffffff, 1'b0, '0},
      '{ROW_CFG,  sscf_pkg::KIND_ENABLE,  2'd0, 32'sd1,        1'b0, '0},
      '{ROW_ITEM, sscf_pkg::KIND_TRIGGER, 2'd0, 32'sd0,        1'b0, '0},
      // successive updates in continuous mode fill the ring past its limit
      '{ROW_ITEM, sscf_pkg::KIND_UPDATE,  2'd0, 32'sd0,        1'b0, '0},
      '{ROW_ITEM, sscf_pkg::KIND_UPDATE,  2'd1, 32'sd0,        1'b0, '0},
      '{ROW_ITEM, sscf_pkg::KIND_UPDATE,  2'd2, 32'sd0,        1'b0, '0},
      '{ROW_ITEM, sscf_pkg::KIND_UPDATE,  2'd3, 32'sd0,        1'b0, '0},
      '{ROW_ITEM, sscf_pkg::KIND_PUSH,    2'd1, 32'sd12345,    1'b0, '0},
      '{ROW_ITEM, sscf_pkg::KIND_CLEAR,   2'd0, 32'sd0,        1'b0, '0},
      '{ROW_ITEM, sscf_pkg::KIND_DISABLE, 2'd3, 32'sd0,        1'b0, '0},
      '{ROW_ITEM, sscf_pkg::KIND_TRIGGER, 2'd1, 32'sd0,        1'b0, '0}
    };

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[n]) begin
      if (dir_rows[n].rk == ROW_CFG) set_continuous(dir_rows[n].val[0]);
      else send_item(dir_rows[n].kind, dir_rows[n].id, dir_rows[n].val,
                     dir_rows[n].fixed, dir_rows[n].want);
    end
    directed_items = sent_items;

    for (int ph = 0; ph < PHASES; ph++) begin
      set_continuous(ph == 0 ? 1'b0 : ph == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
      heavy = (ph == 2) || (ph == 4);
      start = useful_items;
      while (useful_items - start < PHASE_ITEMS) begin
        if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
        if ($urandom_range(0, 79) == 0) drain();
        if ($urandom_range(0, 2) == 0) sample_round();
        else random_item(heavy);
      end
    end
    no_idle = 1'b0;

    drain();
    repeat (DRAIN_TAIL) @(posedge clk_i);
    $display("sent %0d items (%0d directed), checked %0d results, %0d updates",
             sent_items, directed_items, checked_count, update_cnt);
    $display("refused triggers %0d, dropped pushes %0d, empty pops %0d, mismatches %0d",
             refused_cnt, dropped_cnt, empty_cnt, mismatch_count);
    if (mismatch_count == 0 && expected_samples.size() == 0) begin
      $display("sensor_sample_controller_fifo_unit verification clean");
    end else begin
      $display("sensor_sample_controller_fifo_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== sensor_sample_controller_fifo_unit.f =====
rtl/sscf_pkg.sv
rtl/sscf_ring.sv
rtl/sensor_sample_controller_fifo_unit.sv
rtl/sscf_checker.sv
tb/tb_sensor_sample_controller_fifo_unit.sv
